// ===== rtl/bspd_pkg.sv =====
// ----------------------------------------------------------------------------
// bspd_pkg
// Shared types and constants for the beacon steering PD controller.
// ----------------------------------------------------------------------------
package bspd_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_PWM    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_PWM      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_PWM     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_ROW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_COL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AIM_OFFSET    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STRAIGHT_CODE = 3'd6;

  localparam logic [15:0] CENTER_PWM_RST    = 16'd3848;
  localparam logic [15:0] LEFT_PWM_RST      = 16'd4150;
  localparam logic [15:0] RIGHT_PWM_RST     = 16'd3620;
  localparam logic [6:0]  CAPTURE_ROW_RST   = 7'd55;
  localparam logic [6:0]  CAPTURE_COL_RST   = 7'd65;
  localparam logic [3:0]  AIM_OFFSET_RST    = 4'd0;
  localparam logic [7:0]  STRAIGHT_CODE_RST = 8'd10;

  // serial multiply-accumulate unit
  localparam int MUL_W = 34;
  localparam int MP_W  = 15;
  localparam int ERR_W = 17;
  localparam int PC_W  = 15;

  typedef logic signed [MUL_W-1:0] acc_t;

  typedef struct packed {
    logic            start;
    acc_t            init;
    acc_t            mcand;
    logic [MP_W-1:0] mplier;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    acc_t acc;
  } mul_rsp_t;

  // target column polynomial, units of 2^-16
  localparam acc_t POLY_A_LEFT  = 34'sd897;
  localparam acc_t POLY_B_LEFT  = -34'sd23469;
  localparam acc_t POLY_C_LEFT  = 34'sd3780772;
  localparam acc_t POLY_A_RIGHT = -34'sd608;
  localparam acc_t POLY_B_RIGHT = 34'sd12399;
  localparam acc_t POLY_C_RIGHT = 34'sd3116892;

  localparam acc_t RND_Q8  = 34'sd128;
  localparam acc_t RND_Q16 = 34'sd32768;

  // gain schedule, Q8.8
  localparam logic [MP_W-1:0] KP_D_GAIN     = 15'd77;
  localparam logic [MP_W-1:0] KD_GAIN       = 15'd13;
  localparam logic [12:0]     KP_NEAR_BASE  = 13'd291;
  localparam logic [12:0]     KP_FAR_BASE   = 13'd1059;
  localparam logic [14:0]     KP_ROW_OFFSET = 15'd9139;
  localparam logic [14:0]     KP_NEAR_LIMIT = 15'd2560;

  // row bands
  localparam logic [6:0] ROW_ULTRA_ON  = 7'd24;
  localparam logic [6:0] ROW_BAND_MID  = 7'd33;
  localparam logic [6:0] ROW_KP_FAR    = 7'd40;
  localparam logic [6:0] ROW_BAND_NEAR = 7'd42;
  localparam logic [6:0] ROW_AIM_LIMIT = 7'd50;

  localparam logic [15:0] MID_LO_LEFT  = 16'd3634;
  localparam logic [15:0] MID_HI_LEFT  = 16'd4100;
  localparam logic [15:0] MID_LO_RIGHT = 16'd3690;
  localparam logic [15:0] MID_HI_RIGHT = 16'd4000;
  localparam logic [15:0] NEAR_LO      = 16'd3620;
  localparam logic [15:0] NEAR_HI      = 16'd4150;
  localparam logic [15:0] FAR_LO       = 16'd0;
  localparam logic [15:0] FAR_HI       = 16'd65535;
  localparam logic [15:0] STRAIGHT_HI  = 16'd3948;
  localparam logic [15:0] STRAIGHT_LO  = 16'd3748;

  localparam logic [7:0] CAPTURE_MIRROR = 8'd100;
  localparam logic [7:0] LOST_MAX       = 8'd255;

  // speed select codes
  localparam logic [1:0] SPEED_TURN     = 2'd0;
  localparam logic [1:0] SPEED_STRAIGHT = 2'd1;
  localparam logic [1:0] SPEED_ORBIT    = 2'd2;
  localparam logic [1:0] SPEED_KEEP     = 2'd3;

endpackage

// ===== rtl/bspd_mul.sv =====
// ----------------------------------------------------------------------------
// bspd_mul
// Bit-serial multiply-accumulate: acc = init + mcand * mplier, one multiplier
// bit per cycle, finishing as soon as the remaining multiplier bits are zero.
// ----------------------------------------------------------------------------
module bspd_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  bspd_pkg::mul_req_t req,
  output bspd_pkg::mul_rsp_t rsp
);
  import bspd_pkg::*;

  acc_t            acc_r, acc_nxt;
  acc_t            mcand_r, mcand_nxt;
  logic [MP_W-1:0] mplier_r, mplier_nxt;
  logic            busy_r, busy_nxt;

  always_comb begin
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    busy_nxt   = busy_r;
    if (req.start) begin
      acc_nxt    = req.init;
      mcand_nxt  = req.mcand;
      mplier_nxt = req.mplier;
      busy_nxt   = 1'b1;
    end else if (busy_r) begin
      if (mplier_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        if (mplier_r[0]) begin
          acc_nxt = acc_r + mcand_r;
        end
        mcand_nxt  = {mcand_r[MUL_W-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[MP_W-1:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.acc  = acc_r;

endmodule

// ===== rtl/beacon_steering_pd_controller_top.sv =====
// ----------------------------------------------------------------------------
// beacon_steering_pd_controller_top
// Per-frame beacon steering: capture, loss handling and PD servo control.
// ----------------------------------------------------------------------------
// One frame beat is taken whenever in_stall is low, which is whenever no
// earlier frame is still being worked on; a finished result sits in the
// output register, so the next frame can enter while it waits. A blocked
// frame is taken and dropped in the idle state and gives no beat. A lost
// frame passes through the lost and emit states to its result. A seen frame
// runs five products through one bit-serial multiply-accumulate unit that
// takes one multiplier bit per cycle: 77, row (twice), the gain kp (up to
// 15 bits) and 13. Below row 50 kp is at most 12 bits; from row 50 on the
// target column is skipped. A capture ends after the target column,
// skipping the last two products.
// ----------------------------------------------------------------------------
module beacon_steering_pd_controller_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [6:0]                     in_beacon_row,
  input  logic [6:0]                     in_beacon_col,
  input  logic                           in_beacon_lost,
  input  logic                           in_blocked,
  input  logic [7:0]                     in_lamp_mode,
  input  logic                           in_turn_right,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [15:0]                    out_servo_value,
  output logic [1:0]                     out_speed_select,
  output logic                           out_ultrasonic_off,
  output logic                           out_orbiting,
  output logic                           out_reacquire_pulse,
  input  logic                           cfg_we,
  input  logic [bspd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bspd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bspd_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SEEN  = 4'd1;
  localparam logic [3:0] ST_LOST  = 4'd2;
  localparam logic [3:0] ST_KP    = 4'd3;
  localparam logic [3:0] ST_POLY1 = 4'd4;
  localparam logic [3:0] ST_POLY2 = 4'd5;
  localparam logic [3:0] ST_CAPT  = 4'd6;
  localparam logic [3:0] ST_PD1   = 4'd7;
  localparam logic [3:0] ST_PD2   = 4'd8;
  localparam logic [3:0] ST_EMIT  = 4'd9;

  // configuration
  logic [15:0] center_pwm_r, left_pwm_r, right_pwm_r;
  logic [6:0]  capture_row_r, capture_col_r;
  logic [3:0]  aim_offset_r;
  logic [7:0]  straight_code_r;

  // control state
  logic [3:0]              state_r, state_nxt;
  logic [15:0]             servo_older_r, servo_older_nxt;
  logic [15:0]             servo_prev_r, servo_prev_nxt;
  logic [15:0]             servo_now_r, servo_now_nxt;
  logic signed [ERR_W-1:0] last_error_r, last_error_nxt;
  logic [PC_W-1:0]         prev_center_r, prev_center_nxt;
  logic [7:0]              lost_frames_r, lost_frames_nxt;
  logic                    captured_r, captured_nxt;
  logic                    started_r, started_nxt;
  logic                    ultra_hold_r, ultra_hold_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // frame and work registers
  logic [6:0]              row_r, row_nxt;
  logic [6:0]              col_r, col_nxt;
  logic [7:0]              lamp_r, lamp_nxt;
  logic                    right_r, right_nxt;
  logic [MP_W-1:0]         kp_r, kp_nxt;
  logic signed [ERR_W-1:0] err_r, err_nxt;
  logic [1:0]              res_speed_r, res_speed_nxt;
  logic                    res_orbit_r, res_orbit_nxt;
  logic                    res_pulse_r, res_pulse_nxt;
  logic [15:0]             out_servo_r, out_servo_nxt;
  logic [1:0]              out_speed_r, out_speed_nxt;
  logic                    out_ultra_r, out_ultra_nxt;
  logic                    out_orbit_r, out_orbit_nxt;
  logic                    out_pulse_r, out_pulse_nxt;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  // datapath helpers
  logic [15:0]             hard_pwm;
  logic [14:0]             col_q8;
  logic signed [15:0]      d_diff;
  logic [14:0]             d_abs;
  logic [9:0]              kp_q;
  logic [11:0]             row20;
  logic [12:0]             kp_near, kp_far;
  logic [14:0]             kp_hi, kp_sel;
  acc_t                    poly_a, poly_b, poly_c;
  acc_t                    pc_sum, fin_sum;
  logic [PC_W-1:0]         pc_new;
  logic signed [ERR_W-1:0] err_new;
  acc_t                    err_ext, last_ext, diff_ext;
  logic                    capture_hit;
  logic [16:0]             rnd_val;
  logic [15:0]             band_lo, band_hi, pd_servo;
  logic [1:0]              band_speed;
  logic [16:0]             avg_sum;
  logic [7:0]              lost_inc;

  bspd_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_pwm_r    <= CENTER_PWM_RST;
      left_pwm_r      <= LEFT_PWM_RST;
      right_pwm_r     <= RIGHT_PWM_RST;
      capture_row_r   <= CAPTURE_ROW_RST;
      capture_col_r   <= CAPTURE_COL_RST;
      aim_offset_r    <= AIM_OFFSET_RST;
      straight_code_r <= STRAIGHT_CODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_PWM:    center_pwm_r    <= cfg_data;
        REG_LEFT_PWM:      left_pwm_r      <= cfg_data;
        REG_RIGHT_PWM:     right_pwm_r     <= cfg_data;
        REG_CAPTURE_ROW:   capture_row_r   <= cfg_data[6:0];
        REG_CAPTURE_COL:   capture_col_r   <= cfg_data[6:0];
        REG_AIM_OFFSET:    aim_offset_r    <= cfg_data[3:0];
        REG_STRAIGHT_CODE: straight_code_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign hard_pwm = right_r ? right_pwm_r : left_pwm_r;
  assign col_q8   = {col_r, 8'h00};

  // distance to the previous target column
  assign d_diff = $signed({1'b0, col_q8}) - $signed({1'b0, prev_center_r});
  assign d_abs  = d_diff[15] ? 15'(-d_diff) : d_diff[14:0];

  // gain schedule; the multiplier holds 77*d + 128 when the gain is formed
  assign kp_q    = mul_rsp.acc[17:8];
  assign row20   = {1'b0, row_r, 4'h0} + {3'b000, row_r, 2'b00};
  assign kp_near = KP_NEAR_BASE + {3'b000, kp_q} + {1'b0, row20};
  assign kp_far  = KP_FAR_BASE + {1'b0, row20};
  assign kp_hi   = {row_r, 8'h00} - KP_ROW_OFFSET;

  always_comb begin
    if (row_r >= ROW_KP_FAR) begin
      kp_sel = kp_hi;
    end else if (d_abs < KP_NEAR_LIMIT) begin
      kp_sel = {2'b00, kp_near};
    end else begin
      kp_sel = {2'b00, kp_far};
    end
  end

  assign poly_a = right_r ? POLY_A_RIGHT : POLY_A_LEFT;
  assign poly_b = right_r ? POLY_B_RIGHT : POLY_B_LEFT;
  assign poly_c = right_r ? POLY_C_RIGHT : POLY_C_LEFT;

  // target column is always positive, so rounding is a plain add
  assign pc_sum  = mul_rsp.acc + RND_Q8;
  assign pc_new  = pc_sum[PC_W+7:8];
  assign err_new = $signed({2'b00, col_q8}) - $signed({2'b00, pc_new});

  assign err_ext  = {{(MUL_W-ERR_W){err_r[ERR_W-1]}}, err_r};
  assign last_ext = {{(MUL_W-ERR_W){last_error_r[ERR_W-1]}}, last_error_r};
  assign diff_ext = last_ext - err_ext;

  // right rule col < 100 - capture_col, rewritten without a negative bound
  assign capture_hit = (row_r > capture_row_r) && (lamp_r != straight_code_r) &&
                       (right_r ? (({1'b0, col_r} + {1'b0, capture_col_r}) < CAPTURE_MIRROR)
                                : (col_r > capture_col_r));

  // final rounding and band clamp
  assign fin_sum = mul_rsp.acc + RND_Q16;
  assign rnd_val = fin_sum[32:16];

  always_comb begin
    if (row_r < ROW_BAND_MID) begin
      band_lo    = FAR_LO;
      band_hi    = FAR_HI;
      band_speed = ((servo_now_r > STRAIGHT_HI) || (servo_now_r < STRAIGHT_LO)) ?
                   SPEED_TURN : SPEED_STRAIGHT;
    end else if (row_r < ROW_BAND_NEAR) begin
      band_lo    = right_r ? MID_LO_RIGHT : MID_LO_LEFT;
      band_hi    = right_r ? MID_HI_RIGHT : MID_HI_LEFT;
      band_speed = SPEED_TURN;
    end else begin
      band_lo    = NEAR_LO;
      band_hi    = NEAR_HI;
      band_speed = SPEED_ORBIT;
    end
  end

  always_comb begin
    if (mul_rsp.acc[MUL_W-1]) begin
      pd_servo = band_lo;
    end else if (rnd_val > {1'b0, band_hi}) begin
      pd_servo = band_hi;
    end else if (rnd_val < {1'b0, band_lo}) begin
      pd_servo = band_lo;
    end else begin
      pd_servo = rnd_val[15:0];
    end
  end

  assign avg_sum  = {1'b0, servo_prev_r} + {1'b0, servo_older_r};
  assign lost_inc = (lost_frames_r == LOST_MAX) ? lost_frames_r : lost_frames_r + 8'd1;

  always_comb begin
    state_nxt       = state_r;
    servo_older_nxt = servo_older_r;
    servo_prev_nxt  = servo_prev_r;
    servo_now_nxt   = servo_now_r;
    last_error_nxt  = last_error_r;
    prev_center_nxt = prev_center_r;
    lost_frames_nxt = lost_frames_r;
    captured_nxt    = captured_r;
    started_nxt     = started_r;
    ultra_hold_nxt  = ultra_hold_r;
    row_nxt         = row_r;
    col_nxt         = col_r;
    lamp_nxt        = lamp_r;
    right_nxt       = right_r;
    kp_nxt          = kp_r;
    err_nxt         = err_r;
    res_speed_nxt   = res_speed_r;
    res_orbit_nxt   = res_orbit_r;
    res_pulse_nxt   = res_pulse_r;
    out_valid_nxt   = out_valid_r;
    out_servo_nxt   = out_servo_r;
    out_speed_nxt   = out_speed_r;
    out_ultra_nxt   = out_ultra_r;
    out_orbit_nxt   = out_orbit_r;
    out_pulse_nxt   = out_pulse_r;
    mul_req         = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        // blocked frames are taken and dropped here
        if (in_valid && !in_blocked) begin
          row_nxt   = in_beacon_row;
          col_nxt   = in_beacon_col;
          lamp_nxt  = in_lamp_mode;
          right_nxt = in_turn_right;
          state_nxt = in_beacon_lost ? ST_LOST : ST_SEEN;
        end
      end
      ST_LOST: begin
        ultra_hold_nxt  = 1'b1;
        lost_frames_nxt = lost_inc;
        res_speed_nxt   = SPEED_KEEP;
        res_pulse_nxt   = 1'b0;
        servo_older_nxt = servo_prev_r;
        if (lost_frames_r == 8'd0) begin
          if (captured_r) begin
            res_orbit_nxt  = 1'b1;
            captured_nxt   = 1'b0;
            servo_prev_nxt = hard_pwm;
            servo_now_nxt  = hard_pwm;
          end else begin
            res_orbit_nxt  = 1'b0;
            servo_prev_nxt = avg_sum[16:1];
            servo_now_nxt  = avg_sum[16:1];
          end
        end else begin
          res_orbit_nxt  = 1'b1;
          servo_prev_nxt = started_r ? hard_pwm : center_pwm_r;
          servo_now_nxt  = started_r ? hard_pwm : center_pwm_r;
        end
        state_nxt = ST_EMIT;
      end
      ST_SEEN: begin
        started_nxt     = 1'b1;
        res_pulse_nxt   = lost_frames_r >= 8'd2;
        lost_frames_nxt = 8'd0;
        mul_req.start   = 1'b1;
        mul_req.init    = RND_Q8;
        mul_req.mcand   = {{(MUL_W-15){1'b0}}, d_abs};
        mul_req.mplier  = KP_D_GAIN;
        state_nxt       = ST_KP;
      end
      ST_KP: begin
        if (!mul_rsp.busy) begin
          kp_nxt = kp_sel;
          if (row_r < ROW_AIM_LIMIT) begin
            // horner form: (a*row + b)*row + c
            mul_req.start  = 1'b1;
            mul_req.init   = poly_b;
            mul_req.mcand  = poly_a;
            mul_req.mplier = {{(MP_W-7){1'b0}}, row_r};
            state_nxt      = ST_POLY1;
          end else begin
            err_nxt   = '0;
            state_nxt = ST_CAPT;
          end
        end
      end
      ST_POLY1: begin
        if (!mul_rsp.busy) begin
          mul_req.start  = 1'b1;
          mul_req.init   = poly_c + {{(MUL_W-20){1'b0}}, aim_offset_r, 16'h0000};
          mul_req.mcand  = mul_rsp.acc;
          mul_req.mplier = {{(MP_W-7){1'b0}}, row_r};
          state_nxt      = ST_POLY2;
        end
      end
      ST_POLY2: begin
        if (!mul_rsp.busy) begin
          prev_center_nxt = pc_new;
          err_nxt         = err_new;
          state_nxt       = ST_CAPT;
        end
      end
      ST_CAPT: begin
        if (capture_hit) begin
          res_orbit_nxt   = 1'b1;
          res_speed_nxt   = SPEED_KEEP;
          captured_nxt    = 1'b1;
          servo_older_nxt = servo_prev_r;
          servo_prev_nxt  = hard_pwm;
          servo_now_nxt   = hard_pwm;
          state_nxt       = ST_EMIT;
        end else begin
          res_orbit_nxt  = 1'b0;
          mul_req.start  = 1'b1;
          mul_req.init   = {2'b00, center_pwm_r, 16'h0000};
          mul_req.mcand  = -err_ext;
          mul_req.mplier = kp_r;
          state_nxt      = ST_PD1;
        end
      end
      ST_PD1: begin
        if (!mul_rsp.busy) begin
          // derivative term: 13 * (last - err) * 2^8
          mul_req.start  = 1'b1;
          mul_req.init   = mul_rsp.acc;
          mul_req.mcand  = {diff_ext[MUL_W-9:0], 8'h00};
          mul_req.mplier = KD_GAIN;
          state_nxt      = ST_PD2;
        end
      end
      ST_PD2: begin
        if (!mul_rsp.busy) begin
          servo_older_nxt = servo_prev_r;
          servo_prev_nxt  = pd_servo;
          servo_now_nxt   = pd_servo;
          last_error_nxt  = err_r;
          ultra_hold_nxt  = row_r >= ROW_ULTRA_ON;
          res_speed_nxt   = band_speed;
          state_nxt       = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_servo_nxt = servo_now_r;
          out_speed_nxt = res_speed_r;
          out_ultra_nxt = ultra_hold_r;
          out_orbit_nxt = res_orbit_r;
          out_pulse_nxt = res_pulse_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      servo_older_r <= '0;
      servo_prev_r  <= '0;
      servo_now_r   <= CENTER_PWM_RST;
      last_error_r  <= '0;
      prev_center_r <= '0;
      lost_frames_r <= '0;
      captured_r    <= 1'b0;
      started_r     <= 1'b0;
      ultra_hold_r  <= 1'b1;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      servo_older_r <= servo_older_nxt;
      servo_prev_r  <= servo_prev_nxt;
      servo_now_r   <= servo_now_nxt;
      last_error_r  <= last_error_nxt;
      prev_center_r <= prev_center_nxt;
      lost_frames_r <= lost_frames_nxt;
      captured_r    <= captured_nxt;
      started_r     <= started_nxt;
      ultra_hold_r  <= ultra_hold_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r       <= row_nxt;
    col_r       <= col_nxt;
    lamp_r      <= lamp_nxt;
    right_r     <= right_nxt;
    kp_r        <= kp_nxt;
    err_r       <= err_nxt;
    res_speed_r <= res_speed_nxt;
    res_orbit_r <= res_orbit_nxt;
    res_pulse_r <= res_pulse_nxt;
    out_servo_r <= out_servo_nxt;
    out_speed_r <= out_speed_nxt;
    out_ultra_r <= out_ultra_nxt;
    out_orbit_r <= out_orbit_nxt;
    out_pulse_r <= out_pulse_nxt;
  end

  assign in_stall            = state_r != ST_IDLE;
  assign out_valid           = out_valid_r;
  assign out_servo_value     = out_servo_r;
  assign out_speed_select    = out_speed_r;
  assign out_ultrasonic_off  = out_ultra_r;
  assign out_orbiting        = out_orbit_r;
  assign out_reacquire_pulse = out_pulse_r;

  // a product is never launched over one still running
  a_mul_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mul_req.start |-> !mul_rsp.busy)
    else $error("multiplier started while busy");

  // every path to the result beat has pushed the servo history
  a_servo_pushed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (servo_prev_r == servo_now_r))
    else $error("servo history out of step at result");

  // a seen beacon clears the loss count and marks the run as started
  a_seen_clears_loss: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEEN) |=> (lost_frames_r == 8'd0 && started_r))
    else $error("loss count not cleared after seen frame");

  // a result that finds the output slot free is presented next cycle
  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && (!out_valid_r || !out_stall)) |=>
      (out_valid_r && state_r == ST_IDLE))
    else $error("result beat not loaded");

endmodule

// ===== verif/beacon_steering_pd_controller_top_tb.sv =====
// ----------------------------------------------------------------------------
// beacon_steering_pd_controller_top_tb
// Self-checking bench for the beacon steering PD controller. Frames go in
// through a queue-fed driver. A cycle-free predictor of the steering law
// follows every accepted frame, and a monitor compares each servo beat field
// by field. Five register settings run, from reset values through both
// extremes, under varied sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module beacon_steering_pd_controller_top_tb;
  import bspd_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_GAP   = 80;

  typedef struct packed {
    logic [6:0] row;
    logic [6:0] col;
    logic       lost;
    logic       blocked;
    logic [7:0] lamp;
    logic       right;
    logic       drain;
  } frame_t;

  typedef struct packed {
    logic [15:0] servo;
    logic [1:0]  speed;
    logic        ultra;
    logic        orbit;
    logic        pulse;
  } steer_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [6:0]  in_beacon_row = '0;
  logic [6:0]  in_beacon_col = '0;
  logic        in_beacon_lost = 1'b0;
  logic        in_blocked = 1'b0;
  logic [7:0]  in_lamp_mode = '0;
  logic        in_turn_right = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_servo_value;
  logic [1:0]  out_speed_select;
  logic        out_ultrasonic_off;
  logic        out_orbiting;
  logic        out_reacquire_pulse;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  beacon_steering_pd_controller_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_beacon_row       (in_beacon_row),
    .in_beacon_col       (in_beacon_col),
    .in_beacon_lost      (in_beacon_lost),
    .in_blocked          (in_blocked),
    .in_lamp_mode        (in_lamp_mode),
    .in_turn_right       (in_turn_right),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_servo_value     (out_servo_value),
    .out_speed_select    (out_speed_select),
    .out_ultrasonic_off  (out_ultrasonic_off),
    .out_orbiting        (out_orbiting),
    .out_reacquire_pulse (out_reacquire_pulse),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  frame_t frames_q[$];
  steer_t expected_cmds[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_cnt = 0;
  int cycle_cnt = 0;
  int frames_in = 0;
  int blocked_in = 0;
  int beats_checked = 0;
  int orbit_cnt = 0;
  int pulse_cnt = 0;
  logic [7:0] cur_straight = STRAIGHT_CODE_RST;

  // predictor copy of the registers
  logic [15:0] c_center, c_left, c_right;
  logic [6:0]  c_cap_row, c_cap_col;
  logic [3:0]  c_aim;
  logic [7:0]  c_straight;

  // predictor copy of the controller state
  logic [15:0] servo_back2, servo_back1, servo_cur;
  int          err_last, aim_center, miss_run;
  bit          locked_on, tracking, ultra_state;

  function automatic longint round_half_away(input longint x, input int s);
    longint h;
    h = longint'(1) <<< (s - 1);
    if (x >= 0) return (x + h) >>> s;
    return -(((-x) + h) >>> s);
  endfunction

  function automatic void shift_servo(input logic [15:0] v);
    servo_back2 = servo_back1;
    servo_back1 = v;
    servo_cur   = v;
  endfunction

  // returns 1 when the frame yields a servo beat
  function automatic bit steer_frame(input frame_t f, output steer_t res);
    int          row, col, err, kp, d;
    longint      acc, v, lo, hi, r;
    logic [15:0] hard, old_cur;
    res = '0;
    res.speed = SPEED_KEEP;
    row = int'(f.row);
    col = int'(f.col);
    err = 0;
    hard = f.right ? c_right : c_left;
    old_cur = servo_cur;
    if (f.blocked) return 1'b0;

    if (f.lost) begin
      ultra_state = 1'b1;
      if (miss_run < 255) miss_run++;
      if (miss_run <= 1) begin
        if (locked_on) begin
          res.orbit = 1'b1;
          locked_on = 1'b0;
          shift_servo(hard);
        end else begin
          shift_servo(16'((int'(servo_back1) + int'(servo_back2)) >> 1));
        end
      end else begin
        res.orbit = 1'b1;
        shift_servo(tracking ? hard : c_center);
      end
    end else begin
      tracking = 1'b1;
      res.pulse = (miss_run >= 2);
      miss_run = 0;

      // gain is scheduled on the distance to last frame's target column
      d = col * 256 - aim_center;
      if (d < 0) d = -d;
      if (row < 40) begin
        if (d < 10 * 256)
          kp = 691 + int'(round_half_away(77 * longint'(d), 8)) + 20 * (row - 20);
        else
          kp = 1459 + 20 * (row - 20);
      end else begin
        kp = (row - 40) * 256 + 1101;
      end

      if (row < 50) begin
        r = row;
        if (f.right) acc = -608 * r * r + 12399 * r + 3116892;
        else acc = 897 * r * r - 23469 * r + 3780772;
        acc += longint'(c_aim) << 16;
        aim_center = int'(round_half_away(acc, 8));
        err = col * 256 - aim_center;
      end

      if (row > int'(c_cap_row) && f.lamp != c_straight &&
          (f.right ? (col < 100 - int'(c_cap_col)) : (col > int'(c_cap_col)))) begin
        res.orbit = 1'b1;
        locked_on = 1'b1;
        shift_servo(hard);
      end else begin
        acc = (longint'(c_center) << 16) - longint'(kp) * err
              - 13 * (longint'(err) - err_last) * 256;
        v = round_half_away(acc, 16);
        if (row < 33) begin
          ultra_state = (row >= 24);
          res.speed = (old_cur > STRAIGHT_HI || old_cur < STRAIGHT_LO) ?
                      SPEED_TURN : SPEED_STRAIGHT;
          lo = longint'(FAR_LO);
          hi = longint'(FAR_HI);
        end else if (row < 42) begin
          ultra_state = 1'b1;
          res.speed = SPEED_TURN;
          lo = longint'(f.right ? MID_LO_RIGHT : MID_LO_LEFT);
          hi = longint'(f.right ? MID_HI_RIGHT : MID_HI_LEFT);
        end else begin
          ultra_state = 1'b1;
          res.speed = SPEED_ORBIT;
          lo = longint'(NEAR_LO);
          hi = longint'(NEAR_HI);
        end
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        shift_servo(v[15:0]);
        err_last = err;
      end
    end

    res.servo = servo_cur;
    res.ultra = ultra_state;
    return 1'b1;
  endfunction

  function automatic frame_t mk_frame(input int row, input int col, input bit lost,
                                      input bit blocked, input int lamp, input bit right);
    frame_t f;
    f.row = row[6:0];
    f.col = col[6:0];
    f.lost = lost;
    f.blocked = blocked;
    f.lamp = lamp[7:0];
    f.right = right;
    f.drain = 1'b0;
    return f;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_regs(input logic [15:0] center, input logic [15:0] left,
                              input logic [15:0] right, input logic [6:0] cap_row,
                              input logic [6:0] cap_col, input logic [3:0] aim,
                              input logic [7:0] straight);
    write_reg(REG_CENTER_PWM, center);
    write_reg(REG_LEFT_PWM, left);
    write_reg(REG_RIGHT_PWM, right);
    write_reg(REG_CAPTURE_ROW, 16'(cap_row));
    write_reg(REG_CAPTURE_COL, 16'(cap_col));
    write_reg(REG_AIM_OFFSET, 16'(aim));
    write_reg(REG_STRAIGHT_CODE, 16'(straight));
    cur_straight = straight;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (frames_q.size() != 0 || in_valid || expected_cmds.size() != 0);
    // a blocked frame may still be in flight with nothing expected
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  // mostly approach tracks: the beacon drifts down the image toward capture,
  // with short loss runs and blocked frames; the rest is raw noise
  task automatic queue_random(input int n);
    frame_t f;
    int     made, row, col, steps, miss_left;
    bit     right;
    made = 0;
    miss_left = 0;
    while (made < n) begin
      if ($urandom_range(0, 4) == 0) begin
        f = frame_t'($urandom);
        f.drain = ($urandom_range(0, 29) == 0);
        frames_q.push_back(f);
        if (!f.blocked) made++;
      end else begin
        right = 1'($urandom_range(0, 1));
        row = $urandom_range(0, 30);
        col = $urandom_range(20, 100);
        steps = $urandom_range(8, 30);
        repeat (steps) begin
          if (miss_left == 0 && $urandom_range(0, 11) == 0)
            miss_left = $urandom_range(1, 4);
          f = mk_frame(row, col, miss_left != 0, $urandom_range(0, 19) == 0,
                       ($urandom_range(0, 7) == 0) ? int'(cur_straight) :
                       int'($urandom_range(0, 255)), right);
          f.drain = ($urandom_range(0, 39) == 0);
          if (miss_left != 0) miss_left--;
          frames_q.push_back(f);
          if (!f.blocked) made++;
          row += $urandom_range(0, 4);
          if (row > 127) row = 127;
          col += int'($urandom_range(0, 10)) - 5;
          if (col < 0) col = 0;
          if (col > 127) col = 127;
        end
      end
    end
  endtask

  // frame driver
  always @(posedge clk) begin : sender
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) void'(frames_q.pop_front());
      if (!in_valid || !in_stall) begin
        if (frames_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
            (!frames_q[0].drain || (!in_valid && expected_cmds.size() == 0))) begin
          in_valid <= 1'b1;
          in_beacon_row <= frames_q[0].row;
          in_beacon_col <= frames_q[0].col;
          in_beacon_lost <= frames_q[0].lost;
          in_blocked <= frames_q[0].blocked;
          in_lamp_mode <= frames_q[0].lamp;
          in_turn_right <= frames_q[0].right;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : receiver
    out_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin : monitor
    frame_t seen;
    steer_t want;
    if (!rst_n) begin
      c_center = CENTER_PWM_RST;
      c_left = LEFT_PWM_RST;
      c_right = RIGHT_PWM_RST;
      c_cap_row = CAPTURE_ROW_RST;
      c_cap_col = CAPTURE_COL_RST;
      c_aim = AIM_OFFSET_RST;
      c_straight = STRAIGHT_CODE_RST;
      servo_back2 = '0;
      servo_back1 = '0;
      servo_cur = CENTER_PWM_RST;
      err_last = 0;
      aim_center = 0;
      miss_run = 0;
      locked_on = 1'b0;
      tracking = 1'b0;
      ultra_state = 1'b1;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CENTER_PWM:    c_center = cfg_data;
          REG_LEFT_PWM:      c_left = cfg_data;
          REG_RIGHT_PWM:     c_right = cfg_data;
          REG_CAPTURE_ROW:   c_cap_row = cfg_data[6:0];
          REG_CAPTURE_COL:   c_cap_col = cfg_data[6:0];
          REG_AIM_OFFSET:    c_aim = cfg_data[3:0];
          REG_STRAIGHT_CODE: c_straight = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        seen.row = in_beacon_row;
        seen.col = in_beacon_col;
        seen.lost = in_beacon_lost;
        seen.blocked = in_blocked;
        seen.lamp = in_lamp_mode;
        seen.right = in_turn_right;
        seen.drain = 1'b0;
        frames_in++;
        if (in_blocked) blocked_in++;
        if (steer_frame(seen, want)) expected_cmds.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (expected_cmds.size() == 0) begin
          $error("servo beat with nothing expected: servo_value %0d", out_servo_value);
          fail_cnt++;
        end else begin
          want = expected_cmds.pop_front();
          check_field("servo_value", want.servo, out_servo_value);
          check_field("speed_select", 16'(want.speed), 16'(out_speed_select));
          check_field("ultrasonic_off", 16'(want.ultra), 16'(out_ultrasonic_off));
          check_field("orbiting", 16'(want.orbit), 16'(out_orbiting));
          check_field("reacquire_pulse", 16'(want.pulse), 16'(out_reacquire_pulse));
          beats_checked++;
          if (want.orbit) orbit_cnt++;
          if (want.pulse) pulse_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $error("run stalled: %0d beats still expected", expected_cmds.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    frame_t f;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings; lost before any sighting centers after the first miss
    frames_q.push_back(mk_frame(0, 0, 1, 0, 0, 0));
    frames_q.push_back(mk_frame(127, 127, 1, 0, 255, 1));
    frames_q.push_back(mk_frame(0, 0, 0, 0, 0, 0));
    frames_q.push_back(mk_frame(127, 127, 0, 0, 255, 1));
    frames_q.push_back(mk_frame(24, 60, 0, 0, 1, 0));
    frames_q.push_back(mk_frame(32, 64, 0, 0, 2, 1));
    frames_q.push_back(mk_frame(33, 50, 0, 0, 3, 0));
    frames_q.push_back(mk_frame(41, 70, 0, 0, 4, 1));
    frames_q.push_back(mk_frame(42, 55, 0, 0, 5, 0));
    frames_q.push_back(mk_frame(49, 60, 0, 0, 6, 1));
    frames_q.push_back(mk_frame(50, 60, 0, 0, 7, 0));
    frames_q.push_back(mk_frame(30, 30, 0, 1, 8, 0));
    f = mk_frame(60, 100, 0, 0, 3, 0);
    f.drain = 1'b1;
    frames_q.push_back(f);
    // miss right after capture keeps orbiting, then hard turn on longer loss
    frames_q.push_back(mk_frame(60, 100, 1, 0, 3, 0));
    frames_q.push_back(mk_frame(60, 100, 1, 0, 3, 0));
    frames_q.push_back(mk_frame(60, 100, 1, 0, 3, 0));
    frames_q.push_back(mk_frame(20, 58, 0, 0, 3, 0));
    frames_q.push_back(mk_frame(60, 100, 0, 0, int'(STRAIGHT_CODE_RST), 0));
    frames_q.push_back(mk_frame(70, 10, 0, 0, 1, 1));
    frames_q.push_back(mk_frame(70, 10, 1, 0, 1, 1));
    frames_q.push_back(mk_frame(10, 60, 0, 0, 127, 0));
    frames_q.push_back(mk_frame(10, 60, 1, 0, 127, 0));
    frames_q.push_back(mk_frame(56, 66, 0, 0, 9, 0));
    frames_q.push_back(mk_frame(55, 66, 0, 0, 9, 0));
    frames_q.push_back(mk_frame(60, 34, 0, 0, 11, 1));
    frames_q.push_back(mk_frame(60, 35, 0, 0, 11, 1));
    // long blackout pushes the loss count into saturation
    repeat (260) begin
      f = frame_t'($urandom);
      f.lost = 1'b1;
      f.blocked = 1'b0;
      f.drain = 1'b0;
      frames_q.push_back(f);
    end
    frames_q.push_back(mk_frame(15, 57, 0, 0, 0, 0));
    queue_random(14);
    wait_drained();

    program_regs(16'd0, 16'hFFFF, 16'd0, 7'd0, 7'd0, 4'd15, 8'hFF);
    send_idle_pct = 85;
    recv_stall_pct = 0;
    queue_random(14);
    wait_drained();

    program_regs(16'hFFFF, 16'd0, 16'hFFFF, 7'd127, 7'd127, 4'd0, 8'd0);
    send_idle_pct = 0;
    recv_stall_pct = 85;
    queue_random(14);
    wait_drained();

    program_regs(16'($urandom_range(3700, 4000)), 16'($urandom_range(4000, 4300)),
                 16'($urandom_range(3500, 3700)), 7'($urandom_range(30, 70)),
                 7'($urandom_range(20, 110)), 4'($urandom_range(0, 15)),
                 8'($urandom_range(0, 15)));
    send_idle_pct = 33;
    recv_stall_pct = 33;
    queue_random(14);
    wait_drained();

    // mirrored right column goes negative: right captures never fire
    program_regs(CENTER_PWM_RST, LEFT_PWM_RST, RIGHT_PWM_RST, CAPTURE_ROW_RST,
                 7'd101, 4'd7, STRAIGHT_CODE_RST);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_random(14);
    wait_drained();
    @(negedge clk);

    $display("frames sent %0d (%0d blocked), servo beats checked %0d", frames_in,
             blocked_in, beats_checked);
    $display("orbit beats %0d, reacquire pulses %0d, five register settings", orbit_cnt,
             pulse_cnt);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bspd_pkg.sv
rtl/bspd_mul.sv
rtl/beacon_steering_pd_controller_top.sv
verif/beacon_steering_pd_controller_top_tb.sv
